[rtl/core/fts_pkg.sv]
// ----------------------------------------------------------------------------
// fts_pkg - file type sniffer shared definitions
// Kind codes, configuration indexes, reset values, magic numbers, tag
// characters and the snapshot record passed from the byte stage onward.
// ----------------------------------------------------------------------------
package fts_pkg;

    // Number of leading content bytes kept for magic-number tests
    localparam int unsigned PREFIX_BYTES = 8;

    // Result codes
    typedef logic [3:0] t_kind;
    localparam t_kind KIND_BMP    = 4'd0;
    localparam t_kind KIND_JPEG   = 4'd1;
    localparam t_kind KIND_PNG    = 4'd2;
    localparam t_kind KIND_GIF    = 4'd3;
    localparam t_kind KIND_PDF    = 4'd4;
    localparam t_kind KIND_MP3    = 4'd5;
    localparam t_kind KIND_MP4    = 4'd6;
    localparam t_kind KIND_HTML   = 4'd7;
    localparam t_kind KIND_TXT    = 4'd8;
    localparam t_kind KIND_BINARY = 4'd9;

    // Configuration register indexes and reset values
    localparam logic        CFG_TEXT_WINDOW    = 1'b0;
    localparam logic        CFG_MAX_LINE_AVG   = 1'b1;
    localparam logic [15:0] TEXT_WINDOW_RESET  = 16'd512;
    localparam logic [15:0] MAX_LINE_AVG_RESET = 16'd200;

    // Special characters
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // Tag length for "<html" / "<HTML"
    localparam logic [2:0] TAG_LEN = 3'd5;

    // Magic numbers, first content byte in the lowest bits
    localparam logic [15:0] MAGIC_BMP      = 16'h4D42;
    localparam logic [23:0] MAGIC_JPEG     = 24'hFFD8FF;
    localparam logic [7:0]  MAGIC_JPEG_DB  = 8'hDB;
    localparam logic [7:0]  MAGIC_JPEG_E0  = 8'hE0;
    localparam logic [7:0]  MAGIC_JPEG_E1  = 8'hE1;
    localparam logic [63:0] MAGIC_PNG      = 64'h0A1A0A0D474E5089;
    localparam logic [31:0] MAGIC_GIF      = 32'h38464947;
    localparam logic [7:0]  MAGIC_GIF_87   = 8'h37;
    localparam logic [7:0]  MAGIC_GIF_89   = 8'h39;
    localparam logic [7:0]  MAGIC_GIF_A    = 8'h61;
    localparam logic [31:0] MAGIC_PDF      = 32'h46445025;
    localparam logic [15:0] MAGIC_MP3_SYNC = 16'hFBFF;
    localparam logic [23:0] MAGIC_MP3_ID3  = 24'h334449;
    localparam logic [31:0] MAGIC_FTYP     = 32'h70797466;

    // Snapshot of the per-content state taken on the last beat
    typedef struct packed {
        logic [63:0] lead;    // leading bytes
        logic [3:0]  cnt8;    // bytes seen, clipped at PREFIX_BYTES
        logic        nul;     // NUL inside the text window
        logic        tag;     // html tag seen
        logic [15:0] size;    // min(text_window, bytes seen)
        logic [16:0] lines;   // newlines in window + 1
    } t_snap;

    // Character idx of "<html" (upper = 0) or "<HTML" (upper = 1)
    function automatic logic [7:0] tag_char(input logic upper, input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3C;
            3'd1:    c = upper ? 8'h48 : 8'h68;
            3'd2:    c = upper ? 8'h54 : 8'h74;
            3'd3:    c = upper ? 8'h4D : 8'h6D;
            3'd4:    c = upper ? 8'h4C : 8'h6C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/file_type_sniffer_top.sv]
// ----------------------------------------------------------------------------
// file_type_sniffer_top - byte stream file type classifier
// Collects prefix bytes, window newline/NUL statistics and html tag matches
// per content, and on the last beat emits one file kind code.
// ----------------------------------------------------------------------------
//
//  channel   | direction | beat contents
//  ----------+-----------+---------------------------------------------------
//  s (in)    | slave     | tdata[7:0] data_byte, tuser byte_valid,
//            |           | tlast end_of_content
//  m (out)   | master    | tdata[3:0] file_kind, tdata[7:4] zero
//  cfg       | write     | addr 0 text_window, addr 1 max_line_average
//
//  One input beat per clock while the input is not stalled. A result passes
//  from the input register through the snapshot, multiply and output
//  registers; the single 17x17 line-budget multiply has its own stage.
//  Reset (synchronous, active low) clears all counters and valid bits and
//  restores the configuration defaults. Non-last beats keep flowing while a
//  result waits; a last beat stalls the input only when all result stages
//  downstream are full.
// ----------------------------------------------------------------------------
module file_type_sniffer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] byte_valid
    input  logic        i_s_tlast,   // end_of_content
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [3:0] file_kind, [7:4] zero
);

    // ------------------------------------------------------------------
    // Tag matcher step: returns {found, next progress}
    // ------------------------------------------------------------------
    function automatic logic [3:0] tag_step(input logic upper, input logic [2:0] prog,
                                            input logic [7:0] b);
        logic [2:0] p;
        logic       hit;
        hit = 1'b0;
        if (prog < fts_pkg::TAG_LEN && b == fts_pkg::tag_char(upper, prog)) begin
            p = prog + 3'd1;
            if (p == fts_pkg::TAG_LEN) begin
                hit = 1'b1;
                p   = 3'd0;
            end
        end else begin
            p = (b == fts_pkg::tag_char(upper, 3'd0)) ? 3'd1 : 3'd0;
        end
        return {hit, p};
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_text_window;
    logic [15:0] r_max_line_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_window  <= fts_pkg::TEXT_WINDOW_RESET;
            r_max_line_avg <= fts_pkg::MAX_LINE_AVG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fts_pkg::CFG_TEXT_WINDOW:  r_text_window  <= i_cfg_wdata;
                fts_pkg::CFG_MAX_LINE_AVG: r_max_line_avg <= i_cfg_wdata;
                default:                   r_text_window  <= r_text_window;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshakes
    // ------------------------------------------------------------------
    logic r_in_valid, r_in_bvalid, r_in_last;
    logic [7:0] r_in_byte;
    logic r_cls_valid, r_mul_valid, r_out_valid;
    logic out_free, mul_free, cls_free, a_adv, a_fire, b_fire, c_fire, s_accept;

    assign out_free   = !r_out_valid || i_m_tready;
    assign mul_free   = !r_mul_valid || out_free;
    assign cls_free   = !r_cls_valid || mul_free;
    assign a_adv      = !r_in_last || cls_free;
    assign a_fire     = r_in_valid && a_adv;
    assign b_fire     = r_cls_valid && mul_free;
    assign c_fire     = r_mul_valid && out_free;
    assign o_s_tready = !r_in_valid || a_adv;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (a_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte   <= i_s_tdata;
            r_in_bvalid <= i_s_tuser;
            r_in_last   <= i_s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Byte stage: per-content state update
    // ------------------------------------------------------------------
    logic [63:0] r_lead, n_lead;
    logic [15:0] r_bytes_seen, n_bytes_seen;
    logic [15:0] r_newlines, n_newlines;
    logic        r_nul, n_nul;
    logic [2:0]  r_lower_prog, n_lower_prog;
    logic [2:0]  r_upper_prog, n_upper_prog;
    logic        r_tag_found, n_tag_found;
    logic [3:0]  lower_res, upper_res;
    logic        in_window;
    fts_pkg::t_snap snap, r_cls;

    assign in_window = r_bytes_seen < r_text_window;
    assign lower_res = tag_step(1'b0, r_lower_prog, r_in_byte);
    assign upper_res = tag_step(1'b1, r_upper_prog, r_in_byte);

    always_comb begin
        n_lead       = r_lead;
        n_bytes_seen = r_bytes_seen;
        n_newlines   = r_newlines;
        n_nul        = r_nul;
        n_lower_prog = r_lower_prog;
        n_upper_prog = r_upper_prog;
        n_tag_found  = r_tag_found;
        if (r_in_bvalid) begin
            // prefix lanes
            for (int k = 0; k < fts_pkg::PREFIX_BYTES; k++) begin
                if (r_bytes_seen == 16'(k)) begin
                    n_lead[8*k +: 8] = r_in_byte;
                end
            end
            // window statistics
            if (in_window) begin
                if (r_in_byte == fts_pkg::CHAR_NEWLINE) begin
                    if (r_newlines != 16'hFFFF) begin
                        n_newlines = r_newlines + 16'd1;
                    end
                end else if (r_in_byte == fts_pkg::CHAR_NUL) begin
                    n_nul = 1'b1;
                end
            end
            // tag matchers
            n_lower_prog = lower_res[2:0];
            n_upper_prog = upper_res[2:0];
            n_tag_found  = r_tag_found || lower_res[3] || upper_res[3];
            if (r_bytes_seen != 16'hFFFF) begin
                n_bytes_seen = r_bytes_seen + 16'd1;
            end
        end
    end

    // Snapshot for classification
    always_comb begin
        snap.lead  = n_lead;
        snap.cnt8  = (n_bytes_seen >= 16'(fts_pkg::PREFIX_BYTES)) ?
                     4'(fts_pkg::PREFIX_BYTES) : n_bytes_seen[3:0];
        snap.nul   = n_nul;
        snap.tag   = n_tag_found;
        snap.size  = (n_bytes_seen < r_text_window) ? n_bytes_seen : r_text_window;
        snap.lines = {1'b0, n_newlines} + 17'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead       <= '0;
            r_bytes_seen <= '0;
            r_newlines   <= '0;
            r_nul        <= 1'b0;
            r_lower_prog <= '0;
            r_upper_prog <= '0;
            r_tag_found  <= 1'b0;
        end else if (a_fire) begin
            if (r_in_last) begin
                r_lead       <= '0;
                r_bytes_seen <= '0;
                r_newlines   <= '0;
                r_nul        <= 1'b0;
                r_lower_prog <= '0;
                r_upper_prog <= '0;
                r_tag_found  <= 1'b0;
            end else begin
                r_lead       <= n_lead;
                r_bytes_seen <= n_bytes_seen;
                r_newlines   <= n_newlines;
                r_nul        <= n_nul;
                r_lower_prog <= n_lower_prog;
                r_upper_prog <= n_upper_prog;
                r_tag_found  <= n_tag_found;
            end
        end
    end

    // Snapshot register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls_valid <= 1'b0;
        end else if (a_fire && r_in_last) begin
            r_cls_valid <= 1'b1;
        end else if (b_fire) begin
            r_cls_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire && r_in_last) begin
            r_cls <= snap;
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: prefix decode and line budget (max_avg+1)*lines.
    // size / lines <= max_avg  <=>  size < (max_avg + 1) * lines
    // ------------------------------------------------------------------
    logic        pfx_hit;
    fts_pkg::t_kind pfx_kind;
    logic [63:0] ld;
    logic [16:0] avg_p1;
    logic [33:0] n_budget;
    logic        r_mul_pfx_hit, r_mul_nul, r_mul_tag;
    fts_pkg::t_kind r_mul_pfx_kind;
    logic [15:0] r_mul_size;
    logic [33:0] r_mul_budget;

    assign ld       = r_cls.lead;
    assign avg_p1   = {1'b0, r_max_line_avg} + 17'd1;
    assign n_budget = avg_p1 * r_cls.lines;

    // Magic tests in priority order
    always_comb begin
        pfx_hit  = 1'b1;
        pfx_kind = fts_pkg::KIND_BINARY;
        if (r_cls.cnt8 >= 4'd2 && ld[15:0] == fts_pkg::MAGIC_BMP) begin
            pfx_kind = fts_pkg::KIND_BMP;
        end else if (r_cls.cnt8 >= 4'd4 && ld[23:0] == fts_pkg::MAGIC_JPEG &&
                     (ld[31:24] == fts_pkg::MAGIC_JPEG_DB ||
                      ld[31:24] == fts_pkg::MAGIC_JPEG_E0 ||
                      ld[31:24] == fts_pkg::MAGIC_JPEG_E1)) begin
            pfx_kind = fts_pkg::KIND_JPEG;
        end else if (r_cls.cnt8 >= 4'd8 && ld == fts_pkg::MAGIC_PNG) begin
            pfx_kind = fts_pkg::KIND_PNG;
        end else if (r_cls.cnt8 >= 4'd6 && ld[31:0] == fts_pkg::MAGIC_GIF &&
                     (ld[39:32] == fts_pkg::MAGIC_GIF_87 ||
                      ld[39:32] == fts_pkg::MAGIC_GIF_89) &&
                     ld[47:40] == fts_pkg::MAGIC_GIF_A) begin
            pfx_kind = fts_pkg::KIND_GIF;
        end else if (r_cls.cnt8 >= 4'd4 && ld[31:0] == fts_pkg::MAGIC_PDF) begin
            pfx_kind = fts_pkg::KIND_PDF;
        end else if ((r_cls.cnt8 >= 4'd2 && ld[15:0] == fts_pkg::MAGIC_MP3_SYNC) ||
                     (r_cls.cnt8 >= 4'd3 && ld[23:0] == fts_pkg::MAGIC_MP3_ID3)) begin
            pfx_kind = fts_pkg::KIND_MP3;
        end else if (r_cls.cnt8 >= 4'd8 && ld[63:32] == fts_pkg::MAGIC_FTYP) begin
            pfx_kind = fts_pkg::KIND_MP4;
        end else begin
            pfx_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (b_fire) begin
            r_mul_valid <= 1'b1;
        end else if (c_fire) begin
            r_mul_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_mul_pfx_hit  <= pfx_hit;
            r_mul_pfx_kind <= pfx_kind;
            r_mul_nul      <= r_cls.nul;
            r_mul_tag      <= r_cls.tag;
            r_mul_size     <= r_cls.size;
            r_mul_budget   <= n_budget;
        end
    end

    // ------------------------------------------------------------------
    // Output register: final decision
    // ------------------------------------------------------------------
    fts_pkg::t_kind kind, r_out_kind;
    logic is_text;

    assign is_text = {18'd0, r_mul_size} < r_mul_budget;

    always_comb begin
        if (r_mul_pfx_hit) begin
            kind = r_mul_pfx_kind;
        end else if (r_mul_nul || !is_text) begin
            kind = fts_pkg::KIND_BINARY;
        end else begin
            kind = r_mul_tag ? fts_pkg::KIND_HTML : fts_pkg::KIND_TXT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_fire) begin
            r_out_kind <= kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_kind};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_kind <= fts_pkg::KIND_BINARY)
        else $error("file kind out of range");

    a_tag_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lower_prog < fts_pkg::TAG_LEN && r_upper_prog < fts_pkg::TAG_LEN)
        else $error("tag progress reached full length");

    a_nl_le_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_newlines <= r_bytes_seen)
        else $error("more newlines than bytes");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && r_in_last) |=> (r_bytes_seen == 16'd0 && !r_nul && !r_tag_found))
        else $error("state not cleared after last beat");

    a_last_to_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && r_in_last) |=> r_cls_valid)
        else $error("last beat did not reach snapshot stage");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb - file type sniffer testbench
// Streams byte contents into file_type_sniffer_top and predicts the kind code
// of each content from its own model of the prefix, text window and html tag
// logic. Directed corner contents, register extremes, text window boundary
// contents, output backpressure and random phases run in turn. Results are
// checked in order against the queue of predicted kinds.
// ----------------------------------------------------------------------------
module tb;

    // Magic numbers, first content byte in the highest bits
    localparam logic [63:0] MAG_BMP    = 64'h424D;
    localparam logic [63:0] MAG_JPG_DB = 64'hFFD8FFDB;
    localparam logic [63:0] MAG_JPG_E0 = 64'hFFD8FFE0;
    localparam logic [63:0] MAG_JPG_E1 = 64'hFFD8FFE1;
    localparam logic [63:0] MAG_PNG    = 64'h89504E470D0A1A0A;
    localparam logic [63:0] MAG_GIF87  = "GIF87a";
    localparam logic [63:0] MAG_GIF89  = "GIF89a";
    localparam logic [63:0] MAG_PDF    = "%PDF";
    localparam logic [63:0] MAG_SYNC   = 64'hFFFB;
    localparam logic [63:0] MAG_ID3    = "ID3";
    localparam logic [63:0] MAG_FTYP   = "ftyp";
    localparam logic [39:0] TAG_LOWER  = "<html";
    localparam logic [39:0] TAG_UPPER  = "<HTML";
    localparam int          MAGIC_VARIANTS = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;

    // Predicted kinds waiting for their output beat
    fts_pkg::t_kind kind_q[$];
    fts_pkg::t_kind want_kind;
    logic [7:0]  content_q[$];

    // Sniffer model state
    logic [15:0] cfg_window   = fts_pkg::TEXT_WINDOW_RESET;
    logic [15:0] cfg_line_avg = fts_pkg::MAX_LINE_AVG_RESET;
    logic [63:0] pr_lead      = '0;
    logic [15:0] pr_count     = '0;
    logic [15:0] pr_newlines  = '0;
    logic        pr_nul       = 1'b0;
    logic [2:0]  pr_lo        = '0;
    logic [2:0]  pr_up        = '0;
    logic        pr_tag       = 1'b0;

    // Traffic knobs
    bit          gap_on       = 1'b1;
    bit          stall_on     = 1'b1;
    int          junk_pct     = 0;
    int          hold_cycles  = 0;
    int          beats_sent   = 0;
    int          mismatch_cnt = 0;

    file_type_sniffer_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),    // [7:0] data_byte
        .i_s_tuser   (s_tuser),    // [0] byte_valid
        .i_s_tlast   (s_tlast),    // end_of_content
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)     // [3:0] file_kind, [7:4] zero
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Sniffer model
    // ------------------------------------------------------------------------
    function automatic logic [2:0] next_tag(input logic [2:0] prog,
                                            input logic [39:0] tag,
                                            input logic [7:0] b);
        logic [2:0] nxt;
        if (prog < fts_pkg::TAG_LEN && b == tag[8*(4-prog) +: 8]) begin
            nxt = prog + 3'd1;
            if (nxt == fts_pkg::TAG_LEN) begin
                pr_tag = 1'b1;
                nxt    = 3'd0;
            end
        end else begin
            nxt = (b == tag[39:32]) ? 3'd1 : 3'd0;
        end
        return nxt;
    endfunction

    task automatic absorb_byte(input logic [7:0] b);
        if (pr_count < fts_pkg::PREFIX_BYTES)
            pr_lead = pr_lead | (64'(b) << (8 * pr_count[2:0]));
        if (pr_count < cfg_window) begin
            if (b == fts_pkg::CHAR_NEWLINE) begin
                if (pr_newlines != 16'hFFFF)
                    pr_newlines = pr_newlines + 16'd1;
            end else if (b == fts_pkg::CHAR_NUL) begin
                pr_nul = 1'b1;
            end
        end
        pr_lo = next_tag(pr_lo, TAG_LOWER, b);
        pr_up = next_tag(pr_up, TAG_UPPER, b);
        if (pr_count != 16'hFFFF)
            pr_count = pr_count + 16'd1;
    endtask

    // n pattern bytes at content offset off, needs off + n bytes seen
    function automatic bit lead_match(input int off, input logic [63:0] pat, input int n);
        if (pr_count < off + n)
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (pr_lead[8*(off+i) +: 8] != pat[8*(n-1-i) +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic fts_pkg::t_kind content_kind();
        int unsigned size;
        int unsigned lines;
        if (lead_match(0, MAG_BMP, 2))
            return fts_pkg::KIND_BMP;
        if (lead_match(0, MAG_JPG_DB, 4) || lead_match(0, MAG_JPG_E0, 4) ||
            lead_match(0, MAG_JPG_E1, 4))
            return fts_pkg::KIND_JPEG;
        if (lead_match(0, MAG_PNG, 8))
            return fts_pkg::KIND_PNG;
        if (lead_match(0, MAG_GIF87, 6) || lead_match(0, MAG_GIF89, 6))
            return fts_pkg::KIND_GIF;
        if (lead_match(0, MAG_PDF, 4))
            return fts_pkg::KIND_PDF;
        if (lead_match(0, MAG_SYNC, 2) || lead_match(0, MAG_ID3, 3))
            return fts_pkg::KIND_MP3;
        if (lead_match(4, MAG_FTYP, 4))
            return fts_pkg::KIND_MP4;
        if (pr_nul)
            return fts_pkg::KIND_BINARY;
        size  = (pr_count < cfg_window) ? pr_count : cfg_window;
        lines = pr_newlines + 1;
        if (size / lines <= cfg_line_avg)
            return pr_tag ? fts_pkg::KIND_HTML : fts_pkg::KIND_TXT;
        return fts_pkg::KIND_BINARY;
    endfunction

    task automatic clear_content();
        pr_lead     = '0;
        pr_count    = '0;
        pr_newlines = '0;
        pr_nul      = 1'b0;
        pr_lo       = '0;
        pr_up       = '0;
        pr_tag      = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // One input beat; called at a rising edge, returns at the edge it is taken
    task automatic send_beat(input logic [7:0] b, input logic v, input logic eoc);
        if (gap_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= v;
        s_tlast  <= eoc;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (v)
            absorb_byte(b);
        if (v || eoc)
            beats_sent++;
        if (eoc) begin
            kind_q.push_back(content_kind());
            clear_content();
        end
    endtask

    // Sends content_q, last byte flagged or followed by an empty end beat
    task automatic send_content(input bit end_marker);
        int n;
        n = content_q.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < junk_pct)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(content_q[i], 1'b1, (i == n - 1) && !end_marker);
        end
        if (end_marker || n == 0)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        content_q.delete();
    endtask

    task automatic add_pattern(input logic [63:0] pat, input int n);
        for (int i = 0; i < n; i++)
            content_q.push_back(pat[8*(n-1-i) +: 8]);
    endtask

    // Text-like bytes; newlines only when nl is set
    task automatic add_text(input int n, input bit nl);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 15);
            if (nl && r < 2)
                content_q.push_back(fts_pkg::CHAR_NEWLINE);
            else if (r == 2)
                content_q.push_back(" ");
            else if (r == 3)
                content_q.push_back("<");
            else if (r == 4)
                content_q.push_back(8'($urandom_range(65, 90)));
            else
                content_q.push_back(8'($urandom_range(97, 122)));
        end
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++)
            content_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic magic_of(input int k, output logic [63:0] p, output int n);
        case (k)
            0: begin p = MAG_BMP;    n = 2; end
            1: begin p = MAG_JPG_DB; n = 4; end
            2: begin p = MAG_JPG_E0; n = 4; end
            3: begin p = MAG_JPG_E1; n = 4; end
            4: begin p = MAG_PNG;    n = 8; end
            5: begin p = MAG_GIF87;  n = 6; end
            6: begin p = MAG_GIF89;  n = 6; end
            7: begin p = MAG_PDF;    n = 4; end
            8: begin p = MAG_SYNC;   n = 2; end
            default: begin p = MAG_ID3; n = 3; end
        endcase
    endtask

    // One random content: well-formed magic or text most of the time
    task automatic build_random_content();
        int          sel;
        int          n;
        int          idx;
        logic [63:0] p;
        sel = $urandom_range(0, 15);
        if (sel < 5) begin
            magic_of($urandom_range(0, MAGIC_VARIANTS - 1), p, n);
            add_pattern(p, n);
            add_noise($urandom_range(0, 12));
        end else if (sel == 5) begin
            add_noise(4);
            add_pattern(MAG_FTYP, 4);
            add_text($urandom_range(0, 10), 1'b1);
        end else if (sel < 10) begin
            // text, html tags and near-miss tags
            add_text($urandom_range(0, 15), 1'b1);
            case ($urandom_range(0, 5))
                0: add_pattern("<html", 5);
                1: add_pattern("<HTML", 5);
                2: add_pattern("<h<html", 7);
                3: add_pattern("<HTml", 5);
                4: add_pattern("<htm", 4);
                default: ;
            endcase
            add_text($urandom_range(0, 15), 1'b1);
        end else if (sel == 10) begin
            // long lines
            add_text($urandom_range(10, 80), $urandom_range(0, 3) == 0);
        end else if (sel == 11) begin
            add_text($urandom_range(0, 20), 1'b1);
            content_q.push_back(fts_pkg::CHAR_NUL);
            add_text($urandom_range(0, 20), 1'b1);
        end else if (sel < 14) begin
            // truncated or corrupted magic
            magic_of($urandom_range(0, MAGIC_VARIANTS - 1), p, n);
            add_pattern(p, n);
            if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, n)) void'(content_q.pop_back());
            end else begin
                idx = $urandom_range(0, n - 1);
                content_q[idx] = content_q[idx] ^ 8'($urandom_range(1, 255));
                add_text($urandom_range(0, 8), 1'b1);
            end
        end else begin
            add_noise($urandom_range(0, 30));
        end
    endtask

    // Stop offering beats and wait until the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (kind_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == fts_pkg::CFG_TEXT_WINDOW)
            cfg_window = val;
        else
            cfg_line_avg = val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] window, input logic [15:0] line_avg);
        settle();
        write_reg(fts_pkg::CFG_TEXT_WINDOW, window);
        write_reg(fts_pkg::CFG_MAX_LINE_AVG, line_avg);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Empty content, ignored beats, short prefixes, NUL, tags of both cases
    task automatic test_special_contents();
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h42, 1'b0, 1'b0);
        add_pattern(MAG_BMP, 2);
        send_content(1'b0);
        content_q.push_back(8'hFF);
        send_content(1'b1);
        content_q.push_back(fts_pkg::CHAR_NUL);
        send_content(1'b0);
        add_pattern("<html", 5);
        send_content(1'b0);
        add_pattern("<HTML", 5);
        send_content(1'b1);
        add_pattern("<hTML", 5);
        send_content(1'b0);
    endtask

    task automatic test_register_extremes();
        logic [15:0] windows[4]  = '{16'd1, 16'hFFFF, 16'd1, 16'hFFFF};
        logic [15:0] averages[4] = '{16'd1, 16'hFFFF, 16'hFFFF, 16'd1};
        for (int k = 0; k < 4; k++) begin
            set_config(windows[k], averages[k]);
            repeat (3) begin
                build_random_content();
                send_content($urandom_range(0, 3) == 0);
            end
        end
    endtask

    // Short window full of newlines with NUL and tag just past it; then a
    // text longer than the window with the tag near the end
    task automatic test_window_edges();
        junk_pct = 0;
        set_config(16'd16, fts_pkg::MAX_LINE_AVG_RESET);
        repeat (16) content_q.push_back(fts_pkg::CHAR_NEWLINE);
        content_q.push_back(fts_pkg::CHAR_NUL);
        add_pattern("<HTML", 5);
        send_content(1'b0);
        set_config(16'd24, 16'd2);
        add_text(40, 1'b1);
        add_pattern("<html", 5);
        send_content(1'b1);
    endtask

    // Receiver holds off while many short contents pile up
    task automatic test_output_backpressure();
        settle();
        gap_on      = 1'b0;
        hold_cycles = 300;
        repeat (40) begin
            add_text($urandom_range(1, 3), 1'b1);
            send_content(1'b0);
        end
        gap_on = 1'b1;
    endtask

    task automatic test_random_phases();
        int goal;
        junk_pct = 10;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_config($urandom_range(1, 48), $urandom_range(1, 30));
                1: set_config(16'hFFFF, $urandom_range(1, 8));
                2: set_config($urandom_range(1, 4096), 16'hFFFF);
                default: begin
                    set_config($urandom_range(1, 200), $urandom_range(2, 12));
                    gap_on   = 1'b0;
                    stall_on = 1'b0;
                end
            endcase
            goal = beats_sent + 60;
            while (beats_sent < goal) begin
                build_random_content();
                send_content($urandom_range(0, 3) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver ready: random stalls, plus a long hold when requested
    // ------------------------------------------------------------------------
    always begin
        @(posedge clk);
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clk);
            hold_cycles = 0;
            m_tready <= 1'b1;
        end else if (stall_on && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Output check against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (kind_q.size() == 0) begin
                report_mismatch($sformatf("result 0x%02h with no content pending", m_tdata));
            end else begin
                want_kind = kind_q.pop_front();
                if (m_tdata[3:0] !== want_kind)
                    report_mismatch($sformatf("file_kind %0d, predicted %0d",
                                              m_tdata[3:0], want_kind));
                if (m_tdata[7:4] !== 4'd0)
                    report_mismatch($sformatf("pad bits 0x%01h not zero", m_tdata[7:4]));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_contents();
        test_register_extremes();
        test_window_edges();
        test_output_backpressure();
        test_random_phases();
        settle();
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit
    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[file_type_sniffer_top.f]
rtl/core/fts_pkg.sv
rtl/core/file_type_sniffer_top.sv
dv/tb.sv
